@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hpsw_pkg.sv @@
`default_nettype none

package hpsw_pkg;

  // sizes
  localparam int NumRefs  = 8;
  localparam int NumPairs = NumRefs * NumRefs;
  localparam int RefIdxW  = $clog2(NumRefs);
  localparam int PairIdxW = $clog2(NumPairs);
  localparam int MemDepth = 2 * (1 << PairIdxW);
  localparam int ScoreW   = 32;
  localparam int MutW     = 16;
  localparam int McostW   = MutW + 1;
  localparam int SumW     = ((ScoreW > McostW) ? ScoreW : McostW) + 1;

  // port fields
  localparam int RefW      = 8;
  localparam int InDataW   = 16;
  localparam int InUserW   = 2;
  localparam int OutCostW  = 32;
  localparam int OutIdxW   = 6;
  localparam int OutDataW  = 40;

  typedef logic [ScoreW-1:0] score_t;

  localparam score_t ScoreMax  = '1;
  localparam score_t SwitchOne = score_t'(256);
  localparam score_t SwitchTwo = score_t'(512);
  localparam logic [MutW-1:0] MutWeightRst = MutW'(256);

  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StDrain
  } hpsw_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic issue;
    logic finish;
  } hpsw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_cell;
    logic pipe_empty;
    logic out_free;
  } hpsw_sts_t;

  function automatic score_t sat_add(score_t a, score_t b);
    logic [ScoreW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ScoreW] ? ScoreMax : s[ScoreW-1:0];
  endfunction

  function automatic score_t min_score(score_t a, score_t b);
    return (a < b) ? a : b;
  endfunction

  // clamp a score to the 32 bit result field
  function automatic logic [OutCostW-1:0] out_cost(score_t s);
    logic [ScoreW+OutCostW-1:0] wide;
    wide = (ScoreW+OutCostW)'(s);
    return (wide > (ScoreW+OutCostW)'({OutCostW{1'b1}})) ? '1 : wide[OutCostW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/haplotype_pair_switch_dp_top.sv @@
// a column is taken only after all cells of the previous column have left the pipeline
// throughput: one pair cell enters the four stage cell pipeline per cycle and
//   the score store takes one write per cycle
// the next column is accepted while a result still waits in the output register
// reset: minima to all ones, weight to 256, pipeline and handshakes cleared;
//   the score store is not cleared and needs no clearing pass
`default_nettype none

`include "assert_macros.svh"

module haplotype_pair_switch_dp_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [hpsw_pkg::MutW-1:0]            cfg_wdata_i,     // mutation_weight
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // target_allele_a, target_allele_b, ref_alleles[7:0], zero pad
  input  wire  [hpsw_pkg::InDataW-1:0]         s_axis_tdata,
  // first_column, prev_is_block_end
  input  wire  [hpsw_pkg::InUserW-1:0]         s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // column_min_cost[31:0], column_min_index[5:0], zero pad
  output logic [hpsw_pkg::OutDataW-1:0]        m_axis_tdata
);

  hpsw_pkg::hpsw_cmd_t cmd;
  hpsw_pkg::hpsw_sts_t sts;

  hpsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpsw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tdata_o (m_axis_tdata)
  );

  // checks
  `ASSERT_SAME(a_finish_drained, cmd.finish, sts.pipe_empty, "column closed with cells in flight")
  `ASSERT_NEXT(a_finish_shows, cmd.finish, m_axis_tvalid, "closed column not presented")
  `ASSERT_SAME(a_accept_quiet, s_axis_tvalid && s_axis_tready,
               sts.pipe_empty && !cmd.issue, "column accepted while cells in flight")
  `ASSERT_NEXT(a_issue_stops, cmd.issue && sts.last_cell, !cmd.issue,
               "cells issued past the last pair")

endmodule

`default_nettype wire

@@ rtl/hpsw_ctrl.sv @@
`default_nettype none

module hpsw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  hpsw_pkg::hpsw_sts_t sts_i,
  output hpsw_pkg::hpsw_cmd_t cmd_o
);

  hpsw_pkg::hpsw_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpsw_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      hpsw_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = hpsw_pkg::StIssue;
        end
      end
      hpsw_pkg::StIssue: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_cell) begin
          state_d = hpsw_pkg::StDrain;
        end
      end
      hpsw_pkg::StDrain: begin
        if (sts_i.pipe_empty && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = hpsw_pkg::StIdle;
        end
      end
      default: begin
        state_d = hpsw_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/hpsw_dp.sv @@
`default_nettype none

module hpsw_dp (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  hpsw_pkg::hpsw_cmd_t                  cmd_i,
  output hpsw_pkg::hpsw_sts_t                  sts_o,
  input  wire                                  cfg_we_i,
  input  wire  [hpsw_pkg::MutW-1:0]            cfg_wdata_i,
  input  wire  [hpsw_pkg::InDataW-1:0]         in_tdata_i,
  input  wire  [hpsw_pkg::InUserW-1:0]         in_tuser_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [hpsw_pkg::OutDataW-1:0]        out_tdata_o
);

  localparam logic [hpsw_pkg::RefIdxW-1:0] LastRef =
    hpsw_pkg::RefIdxW'(hpsw_pkg::NumRefs - 1);

  // config and latched column
  logic [hpsw_pkg::MutW-1:0] weight_q;
  logic                      start_q, swap_q, ha_q, hb_q;
  logic [hpsw_pkg::RefW-1:0] refs_q;

  // cell counters
  logic [hpsw_pkg::RefIdxW-1:0]  l_q, r_q;
  logic [hpsw_pkg::PairIdxW-1:0] j_q;
  logic [hpsw_pkg::PairIdxW-1:0] swap_addr;
  logic                          row_end;

  // previous column minima as rotating lines
  hpsw_pkg::score_t mbr_rot_q [hpsw_pkg::NumRefs];
  hpsw_pkg::score_t mbl_rot_q [hpsw_pkg::NumRefs];
  hpsw_pkg::score_t mbr_row_q [hpsw_pkg::NumRefs];
  hpsw_pkg::score_t mbl_row_q [hpsw_pkg::NumRefs];
  hpsw_pkg::score_t min_ovr_q;
  logic             bank_q;

  // minima of the column being built
  hpsw_pkg::score_t nr_q [hpsw_pkg::NumRefs];
  hpsw_pkg::score_t nl_q [hpsw_pkg::NumRefs];
  hpsw_pkg::score_t acc_q, best_q;
  logic [hpsw_pkg::PairIdxW-1:0] best_idx_q;

  // score store, two banks
  hpsw_pkg::score_t mem [hpsw_pkg::MemDepth];
  hpsw_pkg::score_t rd_a_q, rd_b_q;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q;
  logic [hpsw_pkg::PairIdxW-1:0] j1_q, j2_q, j3_q, j4_q;
  logic e1_q, e2_q, e3_q, e4_q;
  logic [hpsw_pkg::McostW-1:0] mc1_q, mc2_q, mc3_q;
  hpsw_pkg::score_t s1a_q, s1b_q, s1c_q, s1d_q, s1o_q;
  hpsw_pkg::score_t m1_q, m2_q, m3_q, m4_q;
  hpsw_pkg::score_t sw3_q, cur4_q;

  logic [hpsw_pkg::McostW-1:0] mcost;
  logic                        da, db;
  logic [hpsw_pkg::SumW-1:0]   sum4;
  hpsw_pkg::score_t            sw_min;

  // output register
  logic                                 out_valid_q;
  logic [hpsw_pkg::OutCostW-1:0]        out_cost_q;
  logic [hpsw_pkg::PairIdxW-1:0]        out_idx_q;

  assign swap_addr = hpsw_pkg::PairIdxW'(r_q) * hpsw_pkg::PairIdxW'(hpsw_pkg::NumRefs)
                   + hpsw_pkg::PairIdxW'(l_q);
  assign row_end   = (r_q == LastRef);

  assign sts_o.last_cell  = row_end && (l_q == LastRef);
  assign sts_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // mismatch cost of the issued cell
  assign da = refs_q[l_q] ^ ha_q;
  assign db = refs_q[r_q] ^ hb_q;
  always_comb begin
    unique case ({da, db})
      2'b00:   mcost = '0;
      2'b11:   mcost = {weight_q, 1'b0};
      default: mcost = {1'b0, weight_q};
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= hpsw_pkg::MutWeightRst;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  // latch the column on acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      start_q <= in_tuser_i[0];
      swap_q  <= in_tuser_i[1];
      ha_q    <= in_tdata_i[0];
      hb_q    <= in_tdata_i[1];
      refs_q  <= in_tdata_i[hpsw_pkg::RefW+1:2];
    end
  end

  // cell counters, left outer and right inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= '0;
      r_q <= '0;
      j_q <= '0;
    end else if (cmd_i.load_item) begin
      l_q <= '0;
      r_q <= '0;
      j_q <= '0;
    end else if (cmd_i.issue) begin
      j_q <= j_q + 1'b1;
      if (row_end) begin
        r_q <= '0;
        l_q <= l_q + 1'b1;
      end else begin
        r_q <= r_q + 1'b1;
      end
    end
  end

  // old minima: rotate per cell or per row, reload when the column closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hpsw_pkg::NumRefs; k++) begin
        mbr_rot_q[k] <= hpsw_pkg::ScoreMax;
        mbl_rot_q[k] <= hpsw_pkg::ScoreMax;
        mbr_row_q[k] <= hpsw_pkg::ScoreMax;
        mbl_row_q[k] <= hpsw_pkg::ScoreMax;
      end
      min_ovr_q <= hpsw_pkg::ScoreMax;
      bank_q    <= 1'b0;
    end else if (cmd_i.finish) begin
      for (int k = 0; k < hpsw_pkg::NumRefs; k++) begin
        mbr_rot_q[k] <= nr_q[k];
        mbl_rot_q[k] <= nl_q[k];
        mbr_row_q[k] <= nr_q[k];
        mbl_row_q[k] <= nl_q[k];
      end
      min_ovr_q <= best_q;
      bank_q    <= !bank_q;
    end else if (cmd_i.issue) begin
      for (int k = 0; k < hpsw_pkg::NumRefs - 1; k++) begin
        mbr_rot_q[k] <= mbr_rot_q[k+1];
        mbl_rot_q[k] <= mbl_rot_q[k+1];
      end
      mbr_rot_q[hpsw_pkg::NumRefs-1] <= mbr_rot_q[0];
      mbl_rot_q[hpsw_pkg::NumRefs-1] <= mbl_rot_q[0];
      if (row_end) begin
        for (int k = 0; k < hpsw_pkg::NumRefs - 1; k++) begin
          mbr_row_q[k] <= mbr_row_q[k+1];
          mbl_row_q[k] <= mbl_row_q[k+1];
        end
        mbr_row_q[hpsw_pkg::NumRefs-1] <= mbr_row_q[0];
        mbl_row_q[hpsw_pkg::NumRefs-1] <= mbl_row_q[0];
      end
    end
  end

  // score store: write the finished cell, read own and swapped predecessor
  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      mem[{!bank_q, j4_q}] <= cur4_q;
    end
    rd_a_q <= mem[{bank_q, j_q}];
    rd_b_q <= mem[{bank_q, swap_addr}];
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: switch terms on the old minima
  always_ff @(posedge clk_i) begin
    j1_q  <= j_q;
    e1_q  <= row_end;
    mc1_q <= mcost;
    s1a_q <= hpsw_pkg::sat_add(mbr_rot_q[0], hpsw_pkg::SwitchOne);
    s1b_q <= hpsw_pkg::sat_add(mbl_row_q[0], hpsw_pkg::SwitchOne);
    s1c_q <= hpsw_pkg::sat_add(mbr_row_q[0], hpsw_pkg::SwitchOne);
    s1d_q <= hpsw_pkg::sat_add(mbl_rot_q[0], hpsw_pkg::SwitchOne);
    s1o_q <= hpsw_pkg::sat_add(min_ovr_q, hpsw_pkg::SwitchTwo);
  end

  // stage 2: pairwise minima, swap terms only after a block end
  always_ff @(posedge clk_i) begin
    j2_q  <= j1_q;
    e2_q  <= e1_q;
    mc2_q <= mc1_q;
    m1_q  <= swap_q ? hpsw_pkg::min_score(rd_a_q, rd_b_q) : rd_a_q;
    m2_q  <= hpsw_pkg::min_score(s1a_q, s1b_q);
    m3_q  <= swap_q ? hpsw_pkg::min_score(s1c_q, s1d_q) : hpsw_pkg::ScoreMax;
    m4_q  <= s1o_q;
  end

  // stage 3: best predecessor, zero at the start of a run
  assign sw_min = hpsw_pkg::min_score(hpsw_pkg::min_score(m1_q, m2_q),
                                      hpsw_pkg::min_score(m3_q, m4_q));
  always_ff @(posedge clk_i) begin
    j3_q  <= j2_q;
    e3_q  <= e2_q;
    mc3_q <= mc2_q;
    sw3_q <= start_q ? '0 : sw_min;
  end

  // stage 4: add mismatch cost with saturation
  assign sum4 = hpsw_pkg::SumW'(sw3_q) + hpsw_pkg::SumW'(mc3_q);
  always_ff @(posedge clk_i) begin
    j4_q   <= j3_q;
    e4_q   <= e3_q;
    cur4_q <= (sum4 > hpsw_pkg::SumW'(hpsw_pkg::ScoreMax)) ? hpsw_pkg::ScoreMax
                                                          : hpsw_pkg::ScoreW'(sum4);
  end

  // new minima from finished cells
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      for (int k = 0; k < hpsw_pkg::NumRefs; k++) begin
        nr_q[k] <= hpsw_pkg::ScoreMax;
      end
      acc_q      <= hpsw_pkg::ScoreMax;
      best_q     <= hpsw_pkg::ScoreMax;
      best_idx_q <= '0;
    end else if (v4_q) begin
      for (int k = 0; k < hpsw_pkg::NumRefs - 1; k++) begin
        nr_q[k] <= nr_q[k+1];
      end
      nr_q[hpsw_pkg::NumRefs-1] <= hpsw_pkg::min_score(nr_q[0], cur4_q);
      if (e4_q) begin
        for (int k = 0; k < hpsw_pkg::NumRefs - 1; k++) begin
          nl_q[k] <= nl_q[k+1];
        end
        nl_q[hpsw_pkg::NumRefs-1] <= hpsw_pkg::min_score(acc_q, cur4_q);
        acc_q <= hpsw_pkg::ScoreMax;
      end else begin
        acc_q <= hpsw_pkg::min_score(acc_q, cur4_q);
      end
      if ((j4_q == '0) || (cur4_q < best_q)) begin
        best_q     <= cur4_q;
        best_idx_q <= j4_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_cost_q <= hpsw_pkg::out_cost(best_q);
      out_idx_q  <= best_idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {(hpsw_pkg::OutDataW - hpsw_pkg::OutCostW - hpsw_pkg::OutIdxW)'(0),
                        hpsw_pkg::OutIdxW'(out_idx_q), out_cost_q};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // one variant column as offered on the slave side
  typedef struct packed {
    logic                     first;
    logic                     ta;
    logic                     tb;
    logic [hpsw_pkg::RefW-1:0] refs;
    logic                     blk_end;
  } column_t;

  // column minimum as carried on the master side
  typedef struct packed {
    logic [hpsw_pkg::OutCostW-1:0] cost;
    logic [hpsw_pkg::OutIdxW-1:0]  idx;
  } colmin_t;

  typedef enum int {
    IdleTxLight,
    IdleRxLight,
    IdleNone
  } idle_mode_e;

  localparam int HoldCycles = 400;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [hpsw_pkg::MutW-1:0]     cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [hpsw_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [hpsw_pkg::InUserW-1:0]  s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [hpsw_pkg::OutDataW-1:0] m_axis_tdata;

  haplotype_pair_switch_dp_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // columns waiting to be sent and column minima waiting to be seen
  column_t    col_pending[$];
  colmin_t    colmin_expected[$];
  column_t    col_offered;
  idle_mode_e idle_mode = IdleTxLight;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         mismatches = 0;
  bit         run_open = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;

  // trellis copy: previous column scores and its minima
  logic [hpsw_pkg::MutW-1:0] mut_weight = hpsw_pkg::MutWeightRst;
  hpsw_pkg::score_t          col_prev[hpsw_pkg::NumPairs];
  hpsw_pkg::score_t          best_right[hpsw_pkg::NumRefs];
  hpsw_pkg::score_t          best_left[hpsw_pkg::NumRefs];
  hpsw_pkg::score_t          best_all;

  assign tx_idle_pct = (idle_mode == IdleTxLight) ? 15 : (idle_mode == IdleRxLight) ? 66 : 0;
  assign rx_idle_pct = (idle_mode == IdleTxLight) ? 66 : (idle_mode == IdleRxLight) ? 15 : 0;

  function automatic hpsw_pkg::score_t add_clamp(hpsw_pkg::score_t a, hpsw_pkg::score_t b);
    logic [hpsw_pkg::ScoreW:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_clamp = s[hpsw_pkg::ScoreW] ? hpsw_pkg::ScoreMax : s[hpsw_pkg::ScoreW-1:0];
  endfunction

  function automatic hpsw_pkg::score_t lesser(hpsw_pkg::score_t a, hpsw_pkg::score_t b);
    lesser = (b < a) ? b : a;
  endfunction

  // advance the trellis by one column and return its minimum
  function automatic colmin_t score_column(column_t c);
    hpsw_pkg::score_t nxt[hpsw_pkg::NumPairs];
    hpsw_pkg::score_t via;
    hpsw_pkg::score_t mcost;
    hpsw_pkg::score_t best;
    int               best_at;
    int               j;
    int               m;
    colmin_t          res;
    for (int l = 0; l < hpsw_pkg::NumRefs; l++) begin
      for (int r = 0; r < hpsw_pkg::NumRefs; r++) begin
        j = l * hpsw_pkg::NumRefs + r;
        m = int'(c.refs[l] != c.ta) + int'(c.refs[r] != c.tb);
        mcost = hpsw_pkg::score_t'(mut_weight) * hpsw_pkg::score_t'(m);
        if (c.first) begin
          via = '0;
        end else begin
          via = col_prev[j];
          via = lesser(via, add_clamp(best_right[r], hpsw_pkg::SwitchOne));
          via = lesser(via, add_clamp(best_left[l], hpsw_pkg::SwitchOne));
          via = lesser(via, add_clamp(best_all, hpsw_pkg::SwitchTwo));
          // swapped terms after a block end
          if (c.blk_end) begin
            via = lesser(via, col_prev[r * hpsw_pkg::NumRefs + l]);
            via = lesser(via, add_clamp(best_right[l], hpsw_pkg::SwitchOne));
            via = lesser(via, add_clamp(best_left[r], hpsw_pkg::SwitchOne));
          end
        end
        nxt[j] = add_clamp(via, mcost);
      end
    end
    for (int k = 0; k < hpsw_pkg::NumRefs; k++) begin
      best_right[k] = hpsw_pkg::ScoreMax;
      best_left[k]  = hpsw_pkg::ScoreMax;
    end
    best    = hpsw_pkg::ScoreMax;
    best_at = 0;
    // lowest pair index wins a tie
    for (int l = 0; l < hpsw_pkg::NumRefs; l++) begin
      for (int r = 0; r < hpsw_pkg::NumRefs; r++) begin
        j = l * hpsw_pkg::NumRefs + r;
        col_prev[j] = nxt[j];
        if (nxt[j] < best_right[r]) best_right[r] = nxt[j];
        if (nxt[j] < best_left[l]) best_left[l] = nxt[j];
        if (j == 0 || nxt[j] < best) begin
          best    = nxt[j];
          best_at = j;
        end
      end
    end
    best_all = best;
    res.cost = hpsw_pkg::OutCostW'(best);
    res.idx  = hpsw_pkg::OutIdxW'(best_at);
    score_column = res;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // slave side driver: offers the oldest pending column
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        colmin_expected = {colmin_expected, score_column(col_offered)};
        void'(col_pending.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (col_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= hpsw_pkg::InDataW'({col_pending[0].refs, col_pending[0].tb,
                                               col_pending[0].ta});
          s_axis_tuser  <= {col_pending[0].blk_end, col_pending[0].first};
          col_offered   <= col_pending[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // master side monitor: every result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    colmin_t got;
    colmin_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cost = m_axis_tdata[hpsw_pkg::OutCostW-1:0];
        got.idx  = m_axis_tdata[hpsw_pkg::OutCostW +: hpsw_pkg::OutIdxW];
        if (colmin_expected.size() == 0) begin
          $error("unexpected result beat: cost %0d index %0d", got.cost, got.idx);
          mismatches = mismatches + 1;
        end else begin
          want = colmin_expected.pop_front();
          if (got.cost !== want.cost) begin
            $error("column_min_cost: expected %0d, got %0d", want.cost, got.cost);
            mismatches = mismatches + 1;
          end
          if (got.idx !== want.idx) begin
            $error("column_min_index: expected %0d, got %0d", want.idx, got.idx);
            mismatches = mismatches + 1;
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_col(bit first, bit ta, bit tb, logic [hpsw_pkg::RefW-1:0] refs,
                          bit blk_end);
    column_t c;
    c.first   = first;
    c.ta      = ta;
    c.tb      = tb;
    c.refs    = refs;
    c.blk_end = blk_end;
    col_pending = {col_pending, c};
    run_open = 1'b1;
  endtask

  // mostly long runs of continuing columns, some restarts and block ends
  task automatic push_random(int count);
    bit                        first;
    logic [hpsw_pkg::RefW-1:0] refs;
    for (int i = 0; i < count; i++) begin
      first = !run_open || ($urandom_range(29) == 0);
      case ($urandom_range(7))
        0: refs = '0;
        1: refs = '1;
        default: refs = hpsw_pkg::RefW'($urandom_range(255));
      endcase
      push_col(first, 1'($urandom_range(1)), 1'($urandom_range(1)), refs,
               $urandom_range(9) < 3);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (col_pending.size() != 0 || colmin_expected.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
  endtask

  task automatic set_weight(logic [hpsw_pkg::MutW-1:0] w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    mut_weight  = w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed columns at the reset weight
    push_col(1, 0, 0, 8'h00, 1);
    push_col(0, 1, 1, 8'hFF, 0);
    push_col(0, 0, 1, 8'h0F, 0);
    push_col(0, 1, 0, 8'h0F, 1);
    push_col(0, 1, 0, 8'hF0, 1);
    push_col(0, 0, 0, 8'hFF, 0);
    push_col(0, 1, 1, 8'h00, 0);
    push_col(0, 1, 0, 8'hAA, 1);
    push_col(0, 0, 1, 8'h55, 1);
    push_col(1, 1, 1, 8'h80, 0);
    push_col(0, 1, 1, 8'h01, 0);
    push_col(0, 0, 1, 8'h01, 1);
    wait_drained();

    // largest weight: every mismatch as dear as possible
    set_weight('1);
    push_col(0, 0, 0, 8'hFF, 0);
    push_col(0, 0, 0, 8'hFF, 0);
    push_col(0, 1, 1, 8'h00, 1);
    push_col(0, 1, 0, 8'h3C, 1);
    wait_drained();

    // zero weight: only switch costs remain
    set_weight('0);
    push_col(0, 1, 0, 8'h96, 1);
    push_col(1, 0, 1, 8'h69, 0);
    push_col(0, 0, 0, 8'hFF, 0);
    wait_drained();

    // receiver stalls for a long stretch while columns keep coming
    @(negedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    push_random(150);
    wait_drained();

    set_weight('1);
    push_random(150);
    wait_drained();
    push_random(150);
    wait_drained();

    idle_mode = IdleRxLight;
    set_weight(hpsw_pkg::MutW'($urandom_range(1, 2000)));
    push_random(200);
    wait_drained();
    set_weight(hpsw_pkg::MutW'($urandom_range(65535)));
    push_random(200);
    wait_drained();

    idle_mode = IdleNone;
    set_weight(hpsw_pkg::MutW'(1));
    push_random(200);
    wait_drained();
    set_weight(hpsw_pkg::MutW'(256));
    push_random(200);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
